[rtl/freed_buffer_reuse_cache_unit_assert.svh]
// assertion macros for the freed buffer reuse cache
// used by the controller and datapath modules; expects clk and arst_n in scope
`ifndef FREED_BUFFER_REUSE_CACHE_UNIT_ASSERT_SVH
`define FREED_BUFFER_REUSE_CACHE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FBRC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbrc assertion failed");
`define FBRC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbrc assertion failed");
`else
`define FBRC_ASSERT_IMPL(name, ante, cons)
`define FBRC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/fbrc_pkg.sv]
// shared types and constants for the freed buffer reuse cache
// no dependencies
package fbrc_pkg;

	localparam int SIZE_W   = 48;
	localparam int ALIGN_W  = 5;
	localparam int IOADDR_W = 48;
	localparam int CFG_W    = 48;
	localparam int SLOTCFG_W = 5;

	localparam logic [SIZE_W-1:0]    MAX_SIZE_RST   = '1;
	localparam logic [SLOTCFG_W-1:0] SLOT_COUNT_RST = 5'd16;

	localparam logic REG_MAX_SIZE   = 1'b0;
	localparam logic REG_SLOT_COUNT = 1'b1;

	typedef enum logic {
		ACT_GET    = 1'b0,
		ACT_RETAIN = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_MISS   = 2'd0,
		ST_HIT    = 2'd1,
		ST_STORED = 2'd2,
		ST_EVICT  = 2'd3
	} status_t;

	typedef struct packed {
		action_t               action;
		logic [SIZE_W-1:0]     size_bytes;
		logic [ALIGN_W-1:0]    align_log2;
		logic [IOADDR_W-1:0]   buffer_address;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [IOADDR_W-1:0]   address_out;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic pick;
		logic update;
	} cmd_t;

endpackage

[rtl/fbrc_ctrl.sv]
// sequencing state machine for the freed buffer reuse cache
// depends on fbrc_pkg and freed_buffer_reuse_cache_unit_assert.svh
`include "freed_buffer_reuse_cache_unit_assert.svh"

module fbrc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output fbrc_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_PICK = 4'b0100,
		S_UPD  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_CMP;
			S_CMP:  state_d = S_PICK;
			S_PICK: state_d = S_UPD;
			S_UPD:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_UPD);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.pick    = (state_q == S_PICK);
	assign cmd.update  = (state_q == S_UPD);

	`FBRC_ASSERT_NEXT(a_accept_to_cmp, start && (state_q == S_IDLE), state_q == S_CMP)
	`FBRC_ASSERT_NEXT(a_upd_gives_done, state_q == S_UPD, done_q)
	`FBRC_ASSERT_IMPL(a_done_when_idle, done_q, state_q == S_IDLE)

endmodule

[rtl/fbrc_datapath.sv]
// entry register file, compare, select and update logic of the freed buffer reuse cache
// depends on fbrc_pkg and freed_buffer_reuse_cache_unit_assert.svh
`include "freed_buffer_reuse_cache_unit_assert.svh"

module fbrc_datapath #(
	parameter int SLOTS     = 16,
	parameter int ADDR_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fbrc_pkg::cmd_t               cmd,
	input  fbrc_pkg::req_t               req,
	input  logic                         wr_en,
	input  logic                         wr_index,
	input  logic [fbrc_pkg::CFG_W-1:0]   wr_data,
	output fbrc_pkg::rsp_t               rsp
);

	localparam int CW  = $clog2(SLOTS + 1);
	localparam int CPW = (CW > fbrc_pkg::SLOTCFG_W) ? CW : fbrc_pkg::SLOTCFG_W;

	logic [fbrc_pkg::SIZE_W-1:0]    max_size_q;
	logic [fbrc_pkg::SLOTCFG_W-1:0] slot_count_q;
	logic [CW-1:0]                  count_q;

	logic [fbrc_pkg::SIZE_W-1:0] size_q [SLOTS];
	logic [ADDR_BITS-1:0]        addr_q [SLOTS];

	fbrc_pkg::req_t       req_q;
	logic [SLOTS-1:0]     vec_s1;
	logic                 evict_s1;
	logic [SLOTS-1:0]     ge_s2;
	logic                 any_s2;
	logic [ADDR_BITS-1:0] sel_addr_s2;
	fbrc_pkg::rsp_t       rsp_q;

	logic [CPW-1:0]       sc_ext;
	logic [CW-1:0]        cap;
	logic                 evict;
	logic                 in_range;
	logic [31:0]          amask;
	logic [SLOTS-1:0]     vec_d;
	logic [SLOTS-1:0]     first;
	logic [ADDR_BITS-1:0] sel_addr;

	// effective capacity clamped to 1..SLOTS
	always_comb begin
		sc_ext = CPW'(slot_count_q);
		if (slot_count_q == '0)
			cap = CW'(1);
		else if (sc_ext > CPW'(SLOTS))
			cap = CW'(SLOTS);
		else
			cap = CW'(sc_ext);
	end

	assign evict    = (count_q >= cap) && (count_q != '0);
	assign in_range = (req_q.size_bytes <= max_size_q);
	assign amask    = (32'd1 << req_q.align_log2) - 32'd1;

	// compare stage
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (req_q.action == fbrc_pkg::ACT_GET)
				vec_d[i] = (CW'(i) < count_q) && in_range
					&& (size_q[i] == req_q.size_bytes)
					&& ((addr_q[i][31:0] & amask) == 32'd0);
			else
				vec_d[i] = evict && (count_q == CW'(i + 1));
		end
	end

	// select stage: lowest set bit, the newest match for a get or the oldest entry on eviction
	always_comb begin
		first    = vec_s1 & (~vec_s1 + SLOTS'(1));
		sel_addr = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (first[i])
				sel_addr = sel_addr | addr_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.compare) begin
			vec_s1   <= vec_d;
			evict_s1 <= evict;
		end
		if (cmd.pick) begin
			ge_s2       <= ~(first - SLOTS'(1));
			any_s2      <= |vec_s1;
			sel_addr_s2 <= sel_addr;
		end
	end

	// entry shifting
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (req_q.action == fbrc_pkg::ACT_RETAIN) begin
				size_q[0] <= req_q.size_bytes;
				addr_q[0] <= ADDR_BITS'(req_q.buffer_address);
				for (int i = 1; i < SLOTS; i++) begin
					size_q[i] <= size_q[i-1];
					addr_q[i] <= addr_q[i-1];
				end
			end else if (any_s2) begin
				for (int i = 0; i < SLOTS - 1; i++) begin
					if (ge_s2[i]) begin
						size_q[i] <= size_q[i+1];
						addr_q[i] <= addr_q[i+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q   <= fbrc_pkg::MAX_SIZE_RST;
			slot_count_q <= fbrc_pkg::SLOT_COUNT_RST;
			count_q      <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					fbrc_pkg::REG_MAX_SIZE:
						max_size_q <= fbrc_pkg::SIZE_W'(wr_data);
					fbrc_pkg::REG_SLOT_COUNT:
						slot_count_q <= wr_data[fbrc_pkg::SLOTCFG_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (req_q.action == fbrc_pkg::ACT_RETAIN) begin
					if (!evict_s1)
						count_q <= count_q + CW'(1);
				end else if (any_s2) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (req_q.action == fbrc_pkg::ACT_RETAIN) begin
				rsp_q.status      <= evict_s1 ? fbrc_pkg::ST_EVICT : fbrc_pkg::ST_STORED;
				rsp_q.address_out <= evict_s1 ? fbrc_pkg::IOADDR_W'(sel_addr_s2) : '0;
			end else begin
				rsp_q.status      <= any_s2 ? fbrc_pkg::ST_HIT : fbrc_pkg::ST_MISS;
				rsp_q.address_out <= any_s2 ? fbrc_pkg::IOADDR_W'(sel_addr_s2) : '0;
			end
		end
	end

	assign rsp = rsp_q;

	`FBRC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(SLOTS))
	`FBRC_ASSERT_IMPL(a_hit_needs_entry, cmd.update && any_s2, count_q != '0)
	`FBRC_ASSERT_IMPL(a_one_selected, cmd.pick, $onehot0(first))

endmodule

[rtl/freed_buffer_reuse_cache_unit.sv]
// top level of the freed buffer reuse cache
// depends on fbrc_pkg, fbrc_ctrl and fbrc_datapath
//
// A transaction is accepted on a clock edge with start high and busy low. Each
// transaction passes through compare of all entries, selection of the newest
// match (or of the oldest entry for eviction), and the shift update of the entry
// register file, then the result shows on rsp with done high for exactly one cycle.
// The receiver cannot stall, so the result must be taken in that cycle. A
// new transaction may be accepted in the same cycle that a result is shown,
// but not while busy is high. No clearing pass follows reset; configuration
// writes on wr_en take effect at once and are expected only while busy is low.
module freed_buffer_reuse_cache_unit #(
	parameter int SLOTS     = 16,
	parameter int ADDR_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fbrc_pkg::req_t              req,
	output logic                        done,
	output fbrc_pkg::rsp_t              rsp,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [fbrc_pkg::CFG_W-1:0]  wr_data
);

	fbrc_pkg::cmd_t cmd;

	fbrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	fbrc_datapath #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rsp      (rsp)
	);

endmodule

[sim/tb.sv]
// self-checking testbench for freed_buffer_reuse_cache_unit: directed and random
// get/retain transactions checked against an in-bench model of the buffer list
// depends on fbrc_pkg and the freed_buffer_reuse_cache_unit rtl
module tb;
	import fbrc_pkg::*;

	localparam int CACHE_SLOTS = 16;

	typedef struct packed {
		logic [SIZE_W-1:0]   buf_size;
		logic [IOADDR_W-1:0] buf_addr;
	} held_buf_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                done;
	rsp_t                rsp;
	logic                wr_en;
	logic                wr_index;
	logic [CFG_W-1:0]    wr_data;

	held_buf_t           held[$];
	rsp_t                expected_rsp[$];
	logic [SIZE_W-1:0]   max_size_cfg;
	logic [SLOTCFG_W-1:0] slot_cfg;
	int                  idle_pct;
	int                  fail_count;

	freed_buffer_reuse_cache_unit #(
		.SLOTS(CACHE_SLOTS),
		.ADDR_BITS(IOADDR_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #10 clk = ~clk;

	function automatic logic [47:0] rand48();
		logic [63:0] t;
		t = {$urandom(), $urandom()};
		return t[47:0];
	endfunction

	function automatic rsp_t predict_cache_step(req_t r);
		rsp_t        o;
		logic [63:0] amask;
		held_buf_t   gone;
		int          cap;
		int          hit_at;
		o.status = ST_MISS;
		o.address_out = '0;
		if (r.action == ACT_GET) begin
			amask = (64'd1 << r.align_log2) - 64'd1;
			hit_at = -1;
			if (r.size_bytes <= max_size_cfg) begin
				for (int i = 0; i < held.size() && hit_at < 0; i++) begin
					if (held[i].buf_size == r.size_bytes &&
						({16'd0, held[i].buf_addr} & amask) == 64'd0)
						hit_at = i;
				end
			end
			if (hit_at >= 0) begin
				o.status = ST_HIT;
				o.address_out = held[hit_at].buf_addr;
				held.delete(hit_at);
			end
		end else begin
			cap = int'(slot_cfg);
			if (cap < 1)
				cap = 1;
			if (cap > CACHE_SLOTS)
				cap = CACHE_SLOTS;
			o.status = ST_STORED;
			if (held.size() >= cap && held.size() > 0) begin
				gone = held.pop_back();
				o.status = ST_EVICT;
				o.address_out = gone.buf_addr;
			end
			held.push_front({r.size_bytes, r.buffer_address});
		end
		return o;
	endfunction

	task automatic issue(input action_t act, input logic [SIZE_W-1:0] sz,
		input logic [ALIGN_W-1:0] al, input logic [IOADDR_W-1:0] ad);
		req_t r;
		int   gap;
		r.action = act;
		r.size_bytes = sz;
		r.align_log2 = al;
		r.buffer_address = ad;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(8, 1);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_rsp.push_back(predict_cache_step(r));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		if (idx == REG_MAX_SIZE)
			max_size_cfg = d[SIZE_W-1:0];
		else
			slot_cfg = d[SLOTCFG_W-1:0];
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report_failure($sformatf("unexpected transaction status=%0d addr=%h",
					rsp.status, rsp.address_out));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status || rsp.address_out !== want.address_out)
					report_failure($sformatf(
						"status exp=%0d got=%0d, address_out exp=%h got=%h",
						want.status, rsp.status, want.address_out, rsp.address_out));
			end
		end
	end

	task automatic test_empty_and_extremes();
		issue(ACT_GET, '0, '0, '0);
		issue(ACT_RETAIN, '0, '0, '0);
		issue(ACT_RETAIN, '1, '1, '1);
		issue(ACT_GET, '1, '0, '0);
		issue(ACT_GET, '0, '1, '1);
	endtask

	task automatic test_alignment();
		issue(ACT_RETAIN, 48'd64, '0, 48'h1000);
		issue(ACT_RETAIN, 48'd64, '0, 48'h1008);
		issue(ACT_GET, 48'd64, 5'd4, '0);
		issue(ACT_GET, 48'd64, 5'd3, '0);
		issue(ACT_RETAIN, 48'd5, '0, 48'h8000_0000);
		issue(ACT_RETAIN, 48'd5, '0, 48'h4000_0000);
		issue(ACT_GET, 48'd5, 5'd31, '0);
		issue(ACT_GET, 48'd5, 5'd31, '0);
	endtask

	task automatic test_size_limit();
		drain();
		write_reg(REG_MAX_SIZE, 48'd100);
		issue(ACT_RETAIN, 48'd100, '0, 48'hA000);
		issue(ACT_RETAIN, 48'd101, '0, 48'hB000);
		issue(ACT_GET, 48'd101, '0, '0);
		issue(ACT_GET, 48'd100, '0, '0);
		drain();
		write_reg(REG_MAX_SIZE, '0);
		issue(ACT_RETAIN, '0, '0, 48'hC000);
		issue(ACT_GET, '0, '0, '0);
		issue(ACT_GET, 48'd101, '0, '0);
		drain();
		write_reg(REG_MAX_SIZE, '1);
		issue(ACT_GET, 48'd101, '0, '0);
	endtask

	task automatic test_capacity();
		drain();
		write_reg(REG_SLOT_COUNT, 48'd2);
		issue(ACT_RETAIN, 48'd7, '0, 48'h7000);
		issue(ACT_RETAIN, 48'd7, '0, 48'h7100);
		issue(ACT_RETAIN, 48'd7, '0, 48'h7200);
		drain();
		// zero acts as one; also shrinks below the current count
		write_reg(REG_SLOT_COUNT, 48'd0);
		issue(ACT_RETAIN, 48'd9, '0, 48'h9000);
		issue(ACT_RETAIN, 48'd9, '0, 48'h9100);
		drain();
		write_reg(REG_SLOT_COUNT, 48'd31);
		issue(ACT_RETAIN, 48'd9, '0, 48'h9200);
	endtask

	task automatic test_random();
		logic [SIZE_W-1:0]   size_pool [6];
		int                  pct_by_phase [5];
		logic [SLOTCFG_W-1:0] slot_by_phase [5];
		logic [CFG_W-1:0]    d;
		logic [SIZE_W-1:0]   sz;
		logic [IOADDR_W-1:0] ad;
		logic [ALIGN_W-1:0]  al;
		action_t             act;
		int                  k;
		int                  pick;
		size_pool = '{48'd0, 48'd16, 48'd64, 48'd4096, 48'h1_0000_0000, '1};
		pct_by_phase = '{0, 61, 6, 61, 0};
		slot_by_phase = '{5'd16, 5'd31, 5'd4, 5'd0, 5'd1};
		for (int p = 0; p < 5; p++) begin
			drain();
			idle_pct = pct_by_phase[p];
			d = rand48();
			d[SLOTCFG_W-1:0] = (p == 4) ? 5'($urandom_range(16, 1)) : slot_by_phase[p];
			write_reg(REG_SLOT_COUNT, d);
			case (p)
				1: write_reg(REG_MAX_SIZE, rand48());
				2: write_reg(REG_MAX_SIZE, 48'd4096);
				default: write_reg(REG_MAX_SIZE, '1);
			endcase
			for (int n = 0; n < 250; n++) begin
				act = action_t'($urandom_range(1));
				pick = $urandom_range(99);
				if (act == ACT_GET && held.size() != 0 && pick < 45)
					sz = held[$urandom_range(held.size() - 1)].buf_size;
				else if (pick < 85)
					sz = size_pool[$urandom_range(5)];
				else
					sz = rand48();
				k = $urandom_range(24);
				ad = rand48();
				if ($urandom_range(9) != 0)
					ad = (ad >> k) << k;
				if ($urandom_range(3) != 0)
					al = 5'($urandom_range(12));
				else
					al = 5'($urandom_range(31));
				issue(act, sz, al, ad);
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		wr_en = 1'b0;
		wr_index = REG_MAX_SIZE;
		wr_data = '0;
		max_size_cfg = MAX_SIZE_RST;
		slot_cfg = SLOT_COUNT_RST;
		idle_pct = 0;
		fail_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		idle_pct = 61;
		test_alignment();
		idle_pct = 6;
		test_size_limit();
		idle_pct = 0;
		test_capacity();
		test_random();
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/fbrc_pkg.sv
rtl/fbrc_ctrl.sv
rtl/fbrc_datapath.sv
rtl/freed_buffer_reuse_cache_unit.sv
sim/tb.sv
